/* rtl/rsa_pkg.sv */
// Package for the record slot allocator: beat payload types and status codes.
// No dependencies; imported by the top level.
package rsa_pkg;

  localparam int KEY_W     = 44;
  localparam int PAYLOAD_W = 32;
  localparam int PAGE_W    = 5;
  localparam int SLOT_W    = 2;

  // Command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED     = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                 command;
    logic [KEY_W-1:0]     record_key;
    logic [PAYLOAD_W-1:0] record_payload;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [PAGE_W-1:0]   page_number;
    logic [SLOT_W-1:0]   slot_number;
  } out_item_t;

endpackage

/* rtl/rsa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/record_slot_allocator_top.sv */
// Record slot allocator top level: paged slot table with a LIFO free list.
// Depends on rsa_pkg and rsa_ram.
//
//   channel | signals                      | direction | beat
//   --------+------------------------------+-----------+---------------------------
//   item    | item_valid item_stall item   | in        | command, key, payload
//   result  | result_valid result_stall    | out       | status, page, slot
//
// An add passes through dispatch and then the free-list pop or the append state
// before the result register is loaded; when the table is full, dispatch goes
// straight to emit. A delete scans the slots ever appended, reading one slot per
// cycle through the single read port of the slot RAM and checking each word in
// the cycle after its read. The RAM needs no clearing because only appended
// slots are ever read. item_stall is high while an item is in work; a stalled
// result holds in the output register and the block waits before loading it.
module record_slot_allocator_top
  import rsa_pkg::*;
#(
  parameter int SLOTS_PER_PAGE = 4,
  parameter int DATA_PAGES     = 16,
  parameter int KEY_BITS       = 44
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  localparam int SB = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
  localparam int PB = (DATA_PAGES > 1) ? $clog2(DATA_PAGES) : 1;
  localparam int AW = PB + SB;
  localparam int DEPTH = 1 << AW;
  localparam logic [SB-1:0] LAST_SLOT = SB'(SLOTS_PER_PAGE - 1);
  localparam logic [PB-1:0] LAST_PAGE = PB'(DATA_PAGES - 1);

  typedef struct packed {
    logic                 valid;
    logic                 nxt_valid;
    logic [AW-1:0]        nxt_addr;
    logic [PAYLOAD_W-1:0] payload;
    logic [KEY_BITS-1:0]  key;
  } slot_word_t;

  localparam int WW = $bits(slot_word_t);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_DISPATCH   = 6'b000010,
    S_ADD_FREE   = 6'b000100,
    S_ADD_APPEND = 6'b001000,
    S_SCAN       = 6'b010000,
    S_EMIT       = 6'b100000
  } state_t;

  state_t state;

  // Latched item
  logic                 cmd;
  logic [KEY_BITS-1:0]  key;
  logic [PAYLOAD_W-1:0] payload;

  // Free list head and append position
  logic          free_valid;
  logic [AW-1:0] free_addr;
  logic [PB-1:0] app_page;
  logic [SB-1:0] app_slot;
  logic          app_full;

  // Scan position and the slot whose word is arriving
  logic [PB-1:0] scan_page;
  logic [SB-1:0] scan_slot;
  logic          scan_end;
  logic          chk_valid;
  logic [PB-1:0] chk_page;
  logic [SB-1:0] chk_slot;

  out_item_t res;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  slot_word_t    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata_raw;
  slot_word_t    rd;

  logic scan_stop;
  logic scan_issue;
  logic scan_hit;
  logic out_free;

  assign rd = slot_word_t'(ram_rdata_raw);

  rsa_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign item_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // Scan control
  assign scan_stop  = scan_end ||
                      (!app_full && scan_page == app_page && scan_slot == app_slot);
  assign scan_issue = (state == S_SCAN) && !scan_stop;
  assign scan_hit   = (state == S_SCAN) && chk_valid && rd.valid && (rd.key == key);

  assign ram_raddr = (state == S_SCAN) ? {scan_page, scan_slot} : free_addr;

  // Select the RAM write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_addr;
    ram_wdata = rd;
    unique case (state)
      S_ADD_FREE: begin
        ram_we            = 1'b1;
        ram_waddr         = free_addr;
        ram_wdata         = rd;
        ram_wdata.valid   = 1'b1;
        ram_wdata.payload = payload;
        ram_wdata.key     = key;
      end
      S_ADD_APPEND: begin
        ram_we            = 1'b1;
        ram_waddr         = {app_page, app_slot};
        ram_wdata         = rd;
        ram_wdata.valid   = 1'b1;
        ram_wdata.payload = payload;
        ram_wdata.key     = key;
      end
      S_SCAN: begin
        ram_we              = scan_hit;
        ram_waddr           = {chk_page, chk_slot};
        ram_wdata           = rd;
        ram_wdata.valid     = 1'b0;
        ram_wdata.nxt_valid = free_valid;
        ram_wdata.nxt_addr  = free_addr;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Latch the accepted beat
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      cmd     <= item.command;
      key     <= KEY_BITS'(item.record_key);
      payload <= item.record_payload;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_valid <= 1'b0;
      app_page   <= '0;
      app_slot   <= '0;
      app_full   <= 1'b0;
      scan_end   <= 1'b0;
      chk_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          scan_page <= '0;
          scan_slot <= '0;
          scan_end  <= 1'b0;
          chk_valid <= 1'b0;
          if (item_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (cmd == CMD_DELETE) begin
            state <= S_SCAN;
          end else if (free_valid) begin
            state <= S_ADD_FREE;
          end else if (app_full) begin
            res.status      <= ST_FULL;
            res.page_number <= '0;
            res.slot_number <= '0;
            state           <= S_EMIT;
          end else begin
            state <= S_ADD_APPEND;
          end
        end
        S_ADD_FREE: begin
          // Pop the head; its link becomes the new head
          free_valid      <= rd.nxt_valid;
          free_addr       <= rd.nxt_addr;
          res.status      <= ST_ADDED;
          res.page_number <= PAGE_W'({1'b0, free_addr[AW-1:SB]} + (PB+1)'(1));
          res.slot_number <= SLOT_W'(free_addr[SB-1:0]);
          state           <= S_EMIT;
        end
        S_ADD_APPEND: begin
          res.status      <= ST_ADDED;
          res.page_number <= PAGE_W'({1'b0, app_page} + (PB+1)'(1));
          res.slot_number <= SLOT_W'(app_slot);
          // Advance the append position, opening the next page when full, or marking the table full after the last page
          if (app_slot == LAST_SLOT) begin
            app_slot <= '0;
            if (app_page == LAST_PAGE) begin
              app_full <= 1'b1;
            end else begin
              app_page <= app_page + PB'(1);
            end
          end else begin
            app_slot <= app_slot + SB'(1);
          end
          state <= S_EMIT;
        end
        S_SCAN: begin
          if (scan_hit) begin
            // Push the matched slot onto the free list
            free_valid      <= 1'b1;
            free_addr       <= {chk_page, chk_slot};
            res.status      <= ST_DELETED;
            res.page_number <= PAGE_W'({1'b0, chk_page} + (PB+1)'(1));
            res.slot_number <= SLOT_W'(chk_slot);
            state           <= S_EMIT;
          end else if (!scan_issue && !chk_valid) begin
            res.status      <= ST_NOT_FOUND;
            res.page_number <= '0;
            res.slot_number <= '0;
            state           <= S_EMIT;
          end
          // Issue the next slot read
          chk_valid <= scan_issue;
          chk_page  <= scan_page;
          chk_slot  <= scan_slot;
          if (scan_issue) begin
            if (scan_slot == LAST_SLOT) begin
              scan_slot <= '0;
              if (scan_page == LAST_PAGE) begin
                scan_end <= 1'b1;
              end else begin
                scan_page <= scan_page + PB'(1);
              end
            end else begin
              scan_slot <= scan_slot + SB'(1);
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      result <= res;
    end
  end

endmodule
